/* hw/rtl/rtfa_pkg.sv */
// shared types for the three-wire rtc field access block
// payload structs of the tick and status channels; no dependencies
package rtfa_pkg;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] field_select;
		logic [7:0] set_value;
		logic       line_in;
	} tick_t;

	typedef struct packed {
		logic       enable_pin;
		logic       clock_pin;
		logic       line_out;
		logic       line_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_value;
	} status_t;

endpackage

/* hw/rtl/rtfa_tick_if.sv */
// valid/ready channel carrying one tick request
// depends on rtfa_pkg for the payload type
interface rtfa_tick_if;
	import rtfa_pkg::*;

	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/rtfa_status_if.sv */
// valid/ready channel carrying one line status request
// depends on rtfa_pkg for the payload type
interface rtfa_status_if;
	import rtfa_pkg::*;

	logic    valid;
	logic    ready;
	status_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/three_wire_rtc_field_access.sv */
// three-wire rtc master: one status request per tick request, registered in the status register,
// one request accepted every cycle while the status register is empty or drained.
// sequencer state and the status register sit between the two channels.
// arst_n clears the sequencer to idle, the status register to empty and
// the apb registers to their defaults.
// depends on rtfa_pkg, rtfa_tick_if, rtfa_status_if
module three_wire_rtc_field_access (
	input  logic                 clk,
	input  logic                 arst_n,
	rtfa_tick_if.sink            tick,
	rtfa_status_if.source        status,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import rtfa_pkg::*;

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_START = 3'd1;
	localparam logic [2:0] PH_WLOW  = 3'd2;
	localparam logic [2:0] PH_WHIGH = 3'd3;
	localparam logic [2:0] PH_RLOW  = 3'd4;
	localparam logic [2:0] PH_RHIGH = 3'd5;
	localparam logic [2:0] PH_GAP   = 3'd6;

	localparam logic [1:0] ACT_SET  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] FLD_SEC  = 2'd0;
	localparam logic [1:0] FLD_MIN  = 2'd1;
	localparam logic [1:0] FLD_HOUR = 2'd2;
	localparam logic [1:0] FRAME_UNPROT = 2'd0;
	localparam logic [1:0] FRAME_DATA   = 2'd1;
	localparam logic [1:0] FRAME_PROT   = 2'd2;
	localparam logic [1:0] FRAME_READ   = 2'd3;

	localparam logic [2:0] REG_SEC   = 3'd0;
	localparam logic [2:0] REG_MIN   = 3'd1;
	localparam logic [2:0] REG_HOUR  = 3'd2;
	localparam logic [2:0] REG_PROT  = 3'd3;
	localparam logic [2:0] REG_PON   = 3'd4;
	localparam logic [2:0] REG_HALF  = 3'd5;

	logic [7:0] sec_addr_q, min_addr_q, hour_addr_q, prot_addr_q, prot_on_q, half_q;

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  frame_q, frame_d;
	logic [3:0]  bit_q, bit_d;
	logic [15:0] shift_q, shift_d;
	logic [7:0]  tick_cnt_q, tick_cnt_d;
	logic [7:0]  rd_shift_q, rd_shift_d;
	logic [7:0]  pending_q, pending_d;
	logic [7:0]  last_rd_q, last_rd_d;
	logic [1:0]  field_q, field_d;

	logic        st_valid_q;
	status_t     st_q, st_d;
	logic        accept;
	logic        adv;
	logic        done;
	logic [7:0]  half;
	logic [6:0]  sat;
	logic [14:0] tens_prod;
	logic [3:0]  tens;
	logic [3:0]  ones;
	logic [3:0]  hi_nib;
	logic        cfg_wr;

	function automatic logic [7:0] field_addr(input logic [1:0] sel, input logic [7:0] a_sec,
			input logic [7:0] a_min, input logic [7:0] a_hour);
		logic [7:0] r;
		case (sel)
			FLD_SEC: r = a_sec;
			FLD_MIN: r = a_min;
			default: r = a_hour;
		endcase
		return r;
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_addr_q  <= 8'd128;
			min_addr_q  <= 8'd130;
			hour_addr_q <= 8'd132;
			prot_addr_q <= 8'd142;
			prot_on_q   <= 8'd1;
			half_q      <= 8'd1;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SEC:  sec_addr_q  <= pwdata[7:0];
				REG_MIN:  min_addr_q  <= pwdata[7:0];
				REG_HOUR: hour_addr_q <= pwdata[7:0];
				REG_PROT: prot_addr_q <= pwdata[7:0];
				REG_PON:  prot_on_q   <= pwdata[7:0];
				REG_HALF: half_q      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SEC:  prdata = {24'd0, sec_addr_q};
			REG_MIN:  prdata = {24'd0, min_addr_q};
			REG_HOUR: prdata = {24'd0, hour_addr_q};
			REG_PROT: prdata = {24'd0, prot_addr_q};
			REG_PON:  prdata = {24'd0, prot_on_q};
			REG_HALF: prdata = {24'd0, half_q};
			default:  prdata = 32'd0;
		endcase
	end

	assign tick.ready   = !st_valid_q || status.ready;
	assign accept       = tick.valid && tick.ready;
	assign status.valid = st_valid_q;
	assign status.data  = st_q;

	// binary to bcd, tens by reciprocal of ten (exact below 160 with the 15-bit product)
	assign sat       = (tick.data.set_value > 8'd99) ? 7'd99 : tick.data.set_value[6:0];
	assign tens_prod = 15'(sat * 8'd205);
	assign tens      = tens_prod[14:11];
	assign ones      = 4'(sat - 7'(tens * 4'd10));
	assign hi_nib    = rd_shift_q[7:4];
	assign half      = (half_q == 8'd0) ? 8'd1 : half_q;

	always_comb begin
		phase_d    = phase_q;
		frame_d    = frame_q;
		bit_d      = bit_q;
		shift_d    = shift_q;
		tick_cnt_d = tick_cnt_q;
		rd_shift_d = rd_shift_q;
		pending_d  = pending_q;
		last_rd_d  = last_rd_q;
		field_d    = field_q;
		adv        = 1'b0;
		done       = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (tick.data.action inside {ACT_SET, ACT_READ} &&
					tick.data.field_select inside {FLD_SEC, FLD_MIN, FLD_HOUR}) begin
				bit_d      = 4'd0;
				tick_cnt_d = 8'd0;
				phase_d    = PH_START;
				if (tick.data.action == ACT_SET) begin
					pending_d = {tens, ones};
					field_d   = tick.data.field_select;
					frame_d   = FRAME_UNPROT;
					shift_d   = {8'd0, prot_addr_q};
				end else begin
					frame_d = FRAME_READ;
					shift_d = {8'd0, field_addr(tick.data.field_select, sec_addr_q,
						min_addr_q, hour_addr_q) | 8'd1};
				end
			end
		end else begin
			tick_cnt_d = tick_cnt_q + 8'd1;
			if (tick_cnt_d >= half) begin
				tick_cnt_d = 8'd0;
				adv        = 1'b1;
			end
		end

		if (adv) begin
			case (phase_q)
				PH_START: phase_d = PH_WLOW;
				PH_WLOW:  phase_d = PH_WHIGH;
				PH_WHIGH: begin
					if (frame_q == FRAME_READ) begin
						if (bit_q >= 4'd7) begin
							bit_d      = 4'd0;
							rd_shift_d = 8'd0;
							phase_d    = PH_RLOW;
						end else begin
							bit_d   = bit_q + 4'd1;
							phase_d = PH_WLOW;
						end
					end else if (bit_q == 4'd15) begin
						bit_d = 4'd0;
						if (frame_q >= FRAME_PROT) begin
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							phase_d = PH_GAP;
						end
					end else begin
						bit_d   = bit_q + 4'd1;
						phase_d = PH_WLOW;
					end
				end
				PH_GAP: begin
					frame_d    = frame_q + 2'd1;
					bit_d      = 4'd0;
					tick_cnt_d = 8'd0;
					phase_d    = PH_START;
					case (frame_d)
						FRAME_UNPROT: shift_d = {8'd0, prot_addr_q};
						FRAME_DATA:   shift_d = {pending_q, field_addr(field_q, sec_addr_q,
							min_addr_q, hour_addr_q)};
						default:      shift_d = {prot_on_q, prot_addr_q};
					endcase
				end
				PH_RLOW: begin
					rd_shift_d = rd_shift_q | (8'(tick.data.line_in) << bit_q[2:0]);
					phase_d    = PH_RHIGH;
				end
				PH_RHIGH: begin
					if (bit_q >= 4'd7) begin
						last_rd_d = 8'({hi_nib, 3'b000}) + 8'({hi_nib, 1'b0}) + 8'(rd_shift_q[3:0]);
						bit_d     = 4'd0;
						phase_d   = PH_IDLE;
						done      = 1'b1;
					end else begin
						bit_d   = bit_q + 4'd1;
						phase_d = PH_RLOW;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					bit_d   = 4'd0;
				end
			endcase
		end

		st_d.enable_pin = 1'b0;
		st_d.clock_pin  = 1'b0;
		st_d.line_out   = 1'b0;
		st_d.line_drive = 1'b1;
		case (phase_d)
			PH_START, PH_WLOW: begin
				st_d.enable_pin = 1'b1;
				st_d.line_out   = shift_d[bit_d];
			end
			PH_WHIGH: begin
				st_d.enable_pin = 1'b1;
				st_d.clock_pin  = 1'b1;
				st_d.line_out   = shift_d[bit_d];
			end
			PH_RLOW: begin
				st_d.enable_pin = 1'b1;
				st_d.line_drive = 1'b0;
			end
			PH_RHIGH: begin
				st_d.enable_pin = 1'b1;
				st_d.clock_pin  = 1'b1;
				st_d.line_drive = 1'b0;
			end
			default: ;
		endcase
		st_d.busy_res   = (phase_d != PH_IDLE);
		st_d.done_res   = done;
		st_d.read_value = last_rd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			frame_q    <= 2'd0;
			bit_q      <= 4'd0;
			shift_q    <= 16'd0;
			tick_cnt_q <= 8'd0;
			rd_shift_q <= 8'd0;
			pending_q  <= 8'd0;
			last_rd_q  <= 8'd0;
			field_q    <= 2'd0;
			st_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= phase_d;
				frame_q    <= frame_d;
				bit_q      <= bit_d;
				shift_q    <= shift_d;
				tick_cnt_q <= tick_cnt_d;
				rd_shift_q <= rd_shift_d;
				pending_q  <= pending_d;
				last_rd_q  <= last_rd_d;
				field_q    <= field_d;
				st_valid_q <= 1'b1;
			end else if (status.ready) begin
				st_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_q <= st_d;
		end
	end

endmodule

/* verif/rtfa_tb_pkg.sv */
// codes shared by the testbench top and the link checker: actions, fields, register indexes
// no dependencies
package rtfa_tb_pkg;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SET      = 2'd1,
		ACT_READ     = 2'd2,
		ACT_RESERVED = 2'd3
	} action_e;

	typedef enum logic [1:0] {
		FLD_SECONDS  = 2'd0,
		FLD_MINUTES  = 2'd1,
		FLD_HOURS    = 2'd2,
		FLD_RESERVED = 2'd3
	} field_e;

	typedef enum int {
		REG_SECOND_ADDR  = 0,
		REG_MINUTE_ADDR  = 1,
		REG_HOUR_ADDR    = 2,
		REG_PROTECT_ADDR = 3,
		REG_PROTECT_ON   = 4,
		REG_HALF_PERIOD  = 5,
		REG_SPARE_A      = 6,
		REG_SPARE_B      = 7
	} reg_index_e;

endpackage

/* verif/rtfa_link_checker.sv */
// watches the tick, status and apb ports, predicts each status request of the
// three-wire rtc master and compares it field by field
// depends on rtfa_pkg, rtfa_tb_pkg, rtfa_tick_if, rtfa_status_if
module rtfa_link_checker (
	input  logic        clk,
	input  logic        arst_n,
	rtfa_tick_if        tick_bus,
	rtfa_status_if      status_bus,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import rtfa_pkg::*;
	import rtfa_tb_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_START, SEQ_WLOW, SEQ_WHIGH, SEQ_RLOW, SEQ_RHIGH, SEQ_GAP
	} seq_phase_e;

	localparam logic [1:0] FRAME_UNPROTECT = 2'd0;
	localparam logic [1:0] FRAME_FIELD     = 2'd1;
	localparam logic [1:0] FRAME_PROTECT   = 2'd2;
	localparam logic [1:0] FRAME_READ      = 2'd3;

	logic [7:0]  link_cfg [0:5];
	seq_phase_e  seq_phase;
	logic [1:0]  frame_idx;
	logic [3:0]  bit_idx;
	logic [7:0]  tick_cnt;
	logic [15:0] frame_bits;
	logic [7:0]  sample_bits;
	logic [7:0]  set_bcd;
	logic [7:0]  last_read_value;
	logic [1:0]  field_held;
	status_t     expected_status_q [$];

	function automatic logic [7:0] field_address(input logic [1:0] sel);
		case (sel)
			FLD_SECONDS: return link_cfg[REG_SECOND_ADDR];
			FLD_MINUTES: return link_cfg[REG_MINUTE_ADDR];
			default: return link_cfg[REG_HOUR_ADDR];
		endcase
	endfunction

	// command byte from registers as each frame begins; data 0, bcd or reg
	function automatic void load_frame();
		logic [7:0] cmd, dat;
		case (frame_idx)
			FRAME_UNPROTECT: begin
				cmd = link_cfg[REG_PROTECT_ADDR];
				dat = 8'h00;
			end
			FRAME_FIELD: begin
				cmd = field_address(field_held);
				dat = set_bcd;
			end
			default: begin
				cmd = link_cfg[REG_PROTECT_ADDR];
				dat = link_cfg[REG_PROTECT_ON];
			end
		endcase
		frame_bits = {dat, cmd};
		bit_idx = '0;
		tick_cnt = '0;
		seq_phase = SEQ_START;
	endfunction

	function automatic status_t step_sequencer(input tick_t t);
		logic [7:0] half, clipped;
		logic adv, done;
		status_t s;
		half = (link_cfg[REG_HALF_PERIOD] == 8'd0) ? 8'd1 : link_cfg[REG_HALF_PERIOD];
		adv = 1'b0;
		done = 1'b0;
		if (seq_phase == SEQ_IDLE) begin
			if ((t.action == ACT_SET || t.action == ACT_READ) && t.field_select != FLD_RESERVED) begin
				if (t.action == ACT_SET) begin
					clipped = (t.set_value > 8'd99) ? 8'd99 : t.set_value;
					set_bcd = 8'((clipped / 10) * 16 + clipped % 10);
					field_held = t.field_select;
					frame_idx = FRAME_UNPROTECT;
					load_frame();
				end else begin
					frame_idx = FRAME_READ;
					frame_bits = {8'h00, field_address(t.field_select) | 8'h01};
					bit_idx = '0;
					tick_cnt = '0;
					seq_phase = SEQ_START;
				end
			end
		end else begin
			tick_cnt = tick_cnt + 8'd1;
			if (tick_cnt >= half) begin
				tick_cnt = '0;
				adv = 1'b1;
			end
		end

		if (adv) begin
			case (seq_phase)
				SEQ_START: seq_phase = SEQ_WLOW;
				SEQ_WLOW: seq_phase = SEQ_WHIGH;
				SEQ_WHIGH: begin
					if (frame_idx == FRAME_READ) begin
						if (bit_idx >= 4'd7) begin
							bit_idx = '0;
							sample_bits = '0;
							seq_phase = SEQ_RLOW;
						end else begin
							bit_idx = bit_idx + 4'd1;
							seq_phase = SEQ_WLOW;
						end
					end else if (bit_idx >= 4'd15) begin
						bit_idx = '0;
						if (frame_idx >= FRAME_PROTECT) begin
							seq_phase = SEQ_IDLE;
							done = 1'b1;
						end else begin
							seq_phase = SEQ_GAP;
						end
					end else begin
						bit_idx = bit_idx + 4'd1;
						seq_phase = SEQ_WLOW;
					end
				end
				SEQ_GAP: begin
					frame_idx = frame_idx + 2'd1;
					load_frame();
				end
				SEQ_RLOW: begin
					sample_bits = sample_bits | (8'(t.line_in) << bit_idx[2:0]);
					seq_phase = SEQ_RHIGH;
				end
				SEQ_RHIGH: begin
					if (bit_idx >= 4'd7) begin
						last_read_value = 8'((sample_bits >> 4) * 10 + sample_bits[3:0]);
						bit_idx = '0;
						seq_phase = SEQ_IDLE;
						done = 1'b1;
					end else begin
						bit_idx = bit_idx + 4'd1;
						seq_phase = SEQ_RLOW;
					end
				end
				default: begin
					seq_phase = SEQ_IDLE;
					bit_idx = '0;
				end
			endcase
		end

		s = '0;
		s.line_drive = 1'b1;
		case (seq_phase)
			SEQ_START, SEQ_WLOW: begin
				s.enable_pin = 1'b1;
				s.line_out = frame_bits[bit_idx];
			end
			SEQ_WHIGH: begin
				s.enable_pin = 1'b1;
				s.clock_pin = 1'b1;
				s.line_out = frame_bits[bit_idx];
			end
			SEQ_RLOW: begin
				s.enable_pin = 1'b1;
				s.line_drive = 1'b0;
			end
			SEQ_RHIGH: begin
				s.enable_pin = 1'b1;
				s.clock_pin = 1'b1;
				s.line_drive = 1'b0;
			end
			default: ;
		endcase
		s.busy_res = (seq_phase != SEQ_IDLE);
		s.done_res = done;
		s.read_value = last_read_value;
		return s;
	endfunction

	task automatic compare_field(input string name, input int want, input int got,
			inout int errs);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		status_t want, got;
		int errs;
		if (!arst_n) begin
			link_cfg[REG_SECOND_ADDR] = 8'd128;
			link_cfg[REG_MINUTE_ADDR] = 8'd130;
			link_cfg[REG_HOUR_ADDR] = 8'd132;
			link_cfg[REG_PROTECT_ADDR] = 8'd142;
			link_cfg[REG_PROTECT_ON] = 8'd1;
			link_cfg[REG_HALF_PERIOD] = 8'd1;
			seq_phase = SEQ_IDLE;
			frame_idx = '0;
			bit_idx = '0;
			tick_cnt = '0;
			frame_bits = '0;
			sample_bits = '0;
			set_bcd = '0;
			last_read_value = '0;
			field_held = '0;
			expected_status_q.delete();
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			errs = 0;
			if (status_bus.valid && status_bus.ready) begin
				got = status_bus.data;
				if (expected_status_q.size() == 0) begin
					$display("%0t: status %h arrived with no tick waiting", $time, got);
					errs++;
				end else begin
					want = expected_status_q.pop_front();
					compare_field("enable_pin", want.enable_pin, got.enable_pin, errs);
					compare_field("clock_pin", want.clock_pin, got.clock_pin, errs);
					compare_field("line_out", want.line_out, got.line_out, errs);
					compare_field("line_drive", want.line_drive, got.line_drive, errs);
					compare_field("busy_res", want.busy_res, got.busy_res, errs);
					compare_field("done_res", want.done_res, got.done_res, errs);
					compare_field("read_value", want.read_value, got.read_value, errs);
				end
			end
			if (tick_bus.valid && tick_bus.ready)
				expected_status_q.push_back(step_sequencer(tick_bus.data));
			if (psel && penable && pwrite && pready && paddr[4:2] <= REG_HALF_PERIOD)
				link_cfg[paddr[4:2]] = pwdata[7:0];
			fail_count <= fail_count + errs;
			pending_count <= expected_status_q.size();
		end
	end

endmodule

/* verif/tb.sv */
// top of the three-wire rtc master testbench: clock, reset, tick requests, apb writes,
// status back-pressure and the verdict; checking lives in rtfa_link_checker
// depends on rtfa_pkg, rtfa_tb_pkg, both channel interfaces, the block itself and rtfa_link_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rtfa_pkg::*;
	import rtfa_tb_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int   send_idle = 0;
	int   recv_idle = 0;
	int   quiet_cycles = 0;
	int   fail_count;
	int   pending_count;
	logic link_busy = 1'b0;
	logic line_fixed;
	logic line_level;

	rtfa_tick_if   tick_bus ();
	rtfa_status_if status_bus ();

	always #5 clk = ~clk;

	three_wire_rtc_field_access i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_bus),
		.status  (status_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rtfa_link_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_bus      (tick_bus),
		.status_bus    (status_bus),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always @(posedge clk)
		status_bus.ready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (arst_n && status_bus.valid && status_bus.ready)
			link_busy <= status_bus.data.busy_res;
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_bus.valid && tick_bus.ready) || (status_bus.valid && status_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("three_wire_rtc_field_access: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic tick_t make_tick(input action_e a, input field_e f,
			input logic [7:0] v, input logic l);
		tick_t t;
		t.action = a;
		t.field_select = f;
		t.set_value = v;
		t.line_in = l;
		return t;
	endfunction

	function automatic tick_t quiet_tick();
		tick_t t;
		t.action = ACT_TICK;
		t.field_select = 2'($urandom_range(3));
		t.set_value = 8'($urandom_range(255));
		t.line_in = line_fixed ? line_level : 1'($urandom_range(1));
		return t;
	endfunction

	// actions land on busy ticks too, so most of them are ignored by the sequencer
	function automatic tick_t random_tick();
		tick_t t;
		t.action = 2'($urandom_range(3));
		t.field_select = ($urandom_range(7) == 0) ? FLD_RESERVED : 2'($urandom_range(2));
		t.set_value = $urandom_range(1) ? 8'($urandom_range(99)) : 8'($urandom_range(255));
		t.line_in = 1'($urandom_range(1));
		return t;
	endfunction

	task automatic send_tick(input tick_t t);
		while ($urandom_range(99) < send_idle) begin
			tick_bus.valid <= 1'b0;
			@(posedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.data <= t;
		do @(posedge clk); while (!tick_bus.ready);
	endtask

	// stop sending and wait until every status request is back
	task automatic drain_link();
		tick_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// tick until the sequencer reports idle and every status request is back
	task automatic settle_link();
		forever begin
			drain_link();
			if (!link_busy)
				break;
			while (link_busy) send_tick(quiet_tick());
		end
	endtask

	task automatic write_reg(input reg_index_e idx, input logic [7:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(int'(idx) * 4);
		pwdata <= {24'h0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_link(input logic [7:0] sec_a, input logic [7:0] min_a,
			input logic [7:0] hour_a, input logic [7:0] prot_a, input logic [7:0] prot_v,
			input logic [7:0] half);
		repeat (2) @(posedge clk);
		write_reg(REG_SECOND_ADDR, sec_a);
		write_reg(REG_MINUTE_ADDR, min_a);
		write_reg(REG_HOUR_ADDR, hour_a);
		write_reg(REG_PROTECT_ADDR, prot_a);
		write_reg(REG_PROTECT_ON, prot_v);
		write_reg(REG_HALF_PERIOD, half);
	endtask

	task automatic run_traffic(input int items);
		repeat (items) send_tick(random_tick());
	endtask

	task automatic set_idling(input int snd, input int rcv);
		send_idle = snd;
		recv_idle <= rcv;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_bus.valid = 1'b0;
		tick_bus.data = '0;
		line_fixed = 1'b1;
		line_level = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(14, 51);

		// field extremes and saturation, at the reset register values
		send_tick(make_tick(ACT_SET, FLD_SECONDS, 8'd0, 1'b0));
		settle_link();
		send_tick(make_tick(ACT_SET, FLD_MINUTES, 8'd99, 1'b1));
		settle_link();
		send_tick(make_tick(ACT_SET, FLD_HOURS, 8'd100, 1'b0));
		settle_link();
		send_tick(make_tick(ACT_SET, FLD_SECONDS, 8'd255, 1'b1));
		settle_link();
		send_tick(make_tick(ACT_READ, FLD_SECONDS, 8'd0, 1'b0));
		settle_link();
		line_level = 1'b1;
		send_tick(make_tick(ACT_READ, FLD_MINUTES, 8'd255, 1'b1));
		settle_link();
		line_fixed = 1'b0;
		send_tick(make_tick(ACT_READ, FLD_HOURS, 8'd37, 1'b0));
		settle_link();

		// ignored requests
		send_tick(make_tick(ACT_RESERVED, FLD_SECONDS, 8'd12, 1'b0));
		send_tick(make_tick(ACT_SET, FLD_RESERVED, 8'd12, 1'b1));
		send_tick(make_tick(ACT_READ, FLD_RESERVED, 8'd12, 1'b0));
		send_tick(make_tick(ACT_TICK, FLD_HOURS, 8'd12, 1'b1));
		settle_link();

		// action while busy, then one on the done tick of a set
		send_tick(make_tick(ACT_SET, FLD_HOURS, 8'd42, 1'b0));
		send_tick(make_tick(ACT_READ, FLD_SECONDS, 8'd0, 1'b1));
		settle_link();
		send_tick(make_tick(ACT_SET, FLD_MINUTES, 8'd7, 1'b0));
		repeat (100) send_tick(quiet_tick());
		send_tick(make_tick(ACT_READ, FLD_SECONDS, 8'd0, 1'b1));
		send_tick(make_tick(ACT_READ, FLD_MINUTES, 8'd0, 1'b0));
		settle_link();

		run_traffic(200);
		drain_link();

		set_idling(51, 14);
		program_link(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		run_traffic(130);
		drain_link();

		program_link(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		run_traffic(40);
		drain_link();

		program_link(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), 8'd2);
		run_traffic(130);
		drain_link();

		set_idling(0, 0);
		program_link(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)), 8'd1);
		write_reg(REG_SPARE_A, 8'hff);
		write_reg(REG_SPARE_B, 8'h5a);
		run_traffic(150);
		drain_link();

		program_link(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(5, 3)));
		run_traffic(100);

		drain_link();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("three_wire_rtc_field_access: match");
		else
			$display("three_wire_rtc_field_access: mismatch");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rtfa_pkg.sv
hw/rtl/rtfa_tick_if.sv
hw/rtl/rtfa_status_if.sv
hw/rtl/three_wire_rtc_field_access.sv
verif/rtfa_tb_pkg.sv
verif/rtfa_link_checker.sv
verif/tb.sv
